[hw/rtl/b32d_pkg.sv]
`default_nettype none

package b32d_pkg;

    // Hard ceiling on decoded bytes per string; the programmed capacity is clamped to it where the core uses it.
    localparam int MAX_BYTES = 64;

    localparam int CAP_W   = 7;
    localparam int COUNT_W = 7;
    localparam int BUF_W   = 12;
    localparam int HELD_W  = 4;
    localparam int SYM_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
    } b32d_in_t;

    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         byte_out;
        logic               done_res;
        logic [1:0]         status;
        logic [COUNT_W-1:0] byte_count;
    } b32d_out_t;

    typedef struct packed {
        logic             is_sym;
        logic             is_skip;
        logic [SYM_W-1:0] value;
    } b32d_sym_t;

endpackage

`default_nettype wire

[hw/rtl/b32d_symbol.sv]
`default_nettype none

module b32d_symbol
    import b32d_pkg::*;
(
    input  wire logic [7:0] char_in,
    output b32d_sym_t       sym
);

    logic [7:0] upper;
    logic [7:0] letter_off;
    logic [7:0] digit_off;

    always_comb
    begin
        // fold lower case onto upper case
        if (char_in >= 8'h61 && char_in <= 8'h7A)
        begin
            upper = char_in & 8'hDF;
        end
        else
        begin
            upper = char_in;
        end
        letter_off = upper - 8'h41;
        digit_off  = char_in - 8'h32;

        sym.is_sym  = 1'b0;
        sym.is_skip = 1'b0;
        sym.value   = '0;
        if (upper >= 8'h41 && upper <= 8'h5A)
        begin
            sym.is_sym = 1'b1;
            sym.value  = letter_off[SYM_W-1:0];
        end
        else if (char_in >= 8'h32 && char_in <= 8'h37)
        begin
            sym.is_sym = 1'b1;
            sym.value  = 5'd26 + digit_off[SYM_W-1:0];
        end
        else if (char_in == 8'h20 || char_in == 8'h2D || char_in == 8'h3D)
        begin
            sym.is_skip = 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/b32d_core.sv]
`default_nettype none

module b32d_core
    import b32d_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire b32d_in_t         req,
    input  wire logic [CAP_W-1:0] capacity,
    output b32d_out_t             res
);

    localparam int LIM_W = 9;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_BYTES);

    logic [BUF_W-1:0]   buf_reg,   buf_next;
    logic [HELD_W-1:0]  held_reg,  held_next;
    logic [COUNT_W-1:0] bytes_reg, bytes_next;
    logic [1:0]         err_reg,   err_next;

    b32d_sym_t        sym;
    logic [HELD_W-1:0] held_sum;
    logic [LIM_W-1:0]  limit;

    b32d_symbol u_symbol (
        .char_in (req.char_in),
        .sym     (sym)
    );

    always_comb
    begin
        if ({2'b00, capacity} > MAX_LIM)
        begin
            limit = MAX_LIM;
        end
        else
        begin
            limit = {2'b00, capacity};
        end
    end

    always_comb
    begin
        buf_next   = buf_reg;
        held_next  = held_reg;
        bytes_next = bytes_reg;
        err_next   = err_reg;
        held_sum   = held_reg + 4'd5;
        res        = '0;

        if (req.kind == KIND_END)
        begin
            res.done_res   = 1'b1;
            res.byte_count = bytes_reg;
            if (err_reg != ST_OK)
            begin
                res.status = err_reg;
            end
            else if (bytes_reg == '0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.status = ST_OK;
            end
            buf_next   = '0;
            held_next  = '0;
            bytes_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            // a sticky error freezes the string until its end request
            if (err_reg == ST_OK)
            begin
                if (!sym.is_sym && !sym.is_skip)
                begin
                    err_next = ST_INVALID;
                end
                else if (sym.is_sym)
                begin
                    buf_next  = {buf_reg[BUF_W-SYM_W-1:0], sym.value};
                    held_next = held_sum;
                    if (held_sum >= 4'd8)
                    begin
                        held_next = held_sum - 4'd8;
                        if ({2'b00, bytes_reg} >= limit)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            res.byte_valid = 1'b1;
                            res.byte_out   = 8'(buf_next >> held_next);
                            bytes_next     = bytes_reg + 7'd1;
                        end
                    end
                end
            end
            res.status     = err_next;
            res.byte_count = bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            held_reg  <= '0;
            bytes_reg <= '0;
            err_reg   <= ST_OK;
        end
        else if (step)
        begin
            buf_reg   <= buf_next;
            held_reg  <= held_next;
            bytes_reg <= bytes_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/base32_stream_decoder.sv]
`default_nettype none

// Base32 text decoder taking one character request per cycle and returning exactly one
// result per request, in the following cycle through the result register; the input side
// stays ready while the result register is empty or being drained, so a full-rate stream
// with an always-ready sink is never stalled. Letters of either case and digits
// 2..7 are symbols, space, dash and '=' are skipped, anything else sets a sticky invalid
// error. Bytes come out MSB first as soon as eight bits are held, and a byte that would
// exceed min(byte_capacity, MAX_BYTES) sets a sticky overflow error instead. An end
// request reports the string status and clears the decoder; leftover bits are dropped.
// Write byte_capacity (reset 64) only while no request is in flight.
module base32_stream_decoder
    import b32d_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire b32d_in_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output b32d_out_t             out_data,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    logic [CAP_W-1:0] cap_reg;
    logic             out_valid_reg;
    b32d_out_t        out_data_reg;
    b32d_out_t        res;
    logic             step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    b32d_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req      (in_data),
        .capacity (cap_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
